>>> design/rpem_pkg.sv
// Package: shared constants and types for the reed pair event monitor
`timescale 1ns / 1ps
package rpem_pkg;
  localparam int ReedCount  = 8;
  localparam int GaugeCount = 4;
  localparam int GaugeW     = 2;

  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_ENABLE   = 2'd1;
  localparam logic [1:0] CFG_MODES    = 2'd2;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_DUAL   = 2'd2;

  // Stable per-reed view handed from the reed lanes to the gauge merger
  typedef struct packed {
    logic        closed;
    logic [31:0] count;
    logic [31:0] start;
    logic [31:0] dur;
  } reed_view_t;

  typedef struct packed {
    logic [1:0]  gauge_index;
    logic        new_event;
    logic [31:0] event_time_us;
    logic [31:0] skew_us;
    logic [31:0] closed_time_a_us;
    logic [31:0] closed_time_b_us;
    logic [31:0] event_count;
    logic        reed_a_closed;
    logic        reed_b_closed;
    logic        fault;
    logic [3:0]  fault_bits;
    logic        last_of_run;
  } result_t;
endpackage

>>> design/rpem_if.sv
// Interfaces: sample request channel and gauge result channel
`timescale 1ns / 1ps
interface rpem_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time_us;
  logic [7:0]  reed_levels;
  modport source (output valid, sample_time_us, reed_levels, input ready);
  modport sink (input valid, sample_time_us, reed_levels, output ready);
endinterface

interface rpem_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         gauge_index;
  logic               new_event;
  logic [31:0]        event_time_us;
  logic signed [31:0] skew_us;
  logic [31:0]        closed_time_a_us;
  logic [31:0]        closed_time_b_us;
  logic [31:0]        event_count;
  logic               reed_a_closed;
  logic               reed_b_closed;
  logic               fault;
  logic [3:0]         fault_bits;
  logic               last_of_run;
  modport source (output valid, gauge_index, new_event, event_time_us, skew_us,
    closed_time_a_us, closed_time_b_us, event_count, reed_a_closed, reed_b_closed,
    fault, fault_bits, last_of_run, input ready);
  modport sink (input valid, gauge_index, new_event, event_time_us, skew_us,
    closed_time_a_us, closed_time_b_us, event_count, reed_a_closed, reed_b_closed,
    fault, fault_bits, last_of_run, output ready);
endinterface

>>> design/rpem_reed_lane.sv
// Reed lane: edge arming, debounce and stable level tracking of one reed
`timescale 1ns / 1ps
module rpem_reed_lane
  import rpem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        present,
  input  logic        lv,
  input  logic [31:0] now,
  input  logic [15:0] debounce_us,
  output reed_view_t  view
);
  logic        prev_r, prev_nxt;
  logic        elev_r, elev_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] etime_r, etime_nxt;
  logic        stab_r, stab_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] dur_r, dur_nxt;
  logic [31:0] age;

  assign age = now - etime_nxt;

  // Arm on a level change, then confirm an aged edge
  always_comb begin
    elev_nxt  = elev_r;
    etime_nxt = etime_r;
    pend_nxt  = pend_r;
    stab_nxt  = stab_r;
    cnt_nxt   = cnt_r;
    start_nxt = start_r;
    dur_nxt   = dur_r;
    prev_nxt  = lv;
    if (present && lv != prev_r) begin
      elev_nxt  = lv;
      etime_nxt = now;
      pend_nxt  = 1'b1;
    end
    if (present && pend_nxt && age >= {16'd0, debounce_us} && lv == elev_nxt) begin
      pend_nxt = 1'b0;
      if (lv != stab_r) begin
        stab_nxt = lv;
        if (!lv) begin
          cnt_nxt   = cnt_r + 32'd1;
          start_nxt = etime_nxt;
        end else begin
          dur_nxt = etime_nxt - start_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b1; elev_r <= 1'b1; pend_r <= 1'b0; etime_r <= '0;
      stab_r <= 1'b1; cnt_r <= '0; start_r <= '0; dur_r <= '0;
    end else if (step) begin
      prev_r <= prev_nxt; elev_r <= elev_nxt; pend_r <= pend_nxt;
      etime_r <= etime_nxt; stab_r <= stab_nxt; cnt_r <= cnt_nxt;
      start_r <= start_nxt; dur_r <= dur_nxt;
    end
  end

  assign view = '{closed: ~stab_r, count: cnt_r, start: start_r, dur: dur_r};
endmodule

>>> design/rpem_gauge_merge.sv
// Gauge merger: pairs reed lanes into gauges, one gauge per cycle while step is high
`timescale 1ns / 1ps
module rpem_gauge_merge
  import rpem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  logic [7:0]  new_modes,
  input  logic        step,
  input  logic [1:0]  g,
  input  logic [7:0]  modes,
  input  logic [7:0]  en_mask,
  input  reed_view_t  va,
  input  reed_view_t  vb,
  output result_t     res
);
  logic [31:0] seen_a_r [GaugeCount];
  logic [31:0] seen_b_r [GaugeCount];
  logic [31:0] rec0_r [GaugeCount];
  logic [31:0] rec1_r [GaugeCount];
  logic [31:0] rec2_r [GaugeCount];
  logic [31:0] rec3_r [GaugeCount];
  logic [31:0] tot_r [GaugeCount];
  logic [3:0]  flt_r [GaugeCount];

  logic [1:0]  mode;
  logic        has_a, has_b, new_a, new_b, upd, a_cl, b_cl, fault;
  logic [3:0]  flt_nxt;
  logic [31:0] r0, r1, r2, r3;

  always_comb begin
    mode = modes[{g, 1'b0} +: 2];
    if (mode == 2'd3) mode = MODE_OFF;
    has_a = en_mask[{g, 1'b0}];
    has_b = en_mask[{g, 1'b1}];
    new_a = va.count != seen_a_r[g];
    new_b = vb.count != seen_b_r[g];
    upd = 1'b0; a_cl = 1'b0; b_cl = 1'b0; fault = 1'b0;
    flt_nxt = {3'b0, flt_r[g][0]};
    r0 = rec0_r[g]; r1 = rec1_r[g]; r2 = rec2_r[g]; r3 = rec3_r[g];
    // Classify the gauge and build its record
    if (mode == MODE_OFF) begin
      flt_nxt = 4'b0001;
    end else begin
      flt_nxt = 4'b0000;
      if (!has_a) begin
        fault = 1'b1; flt_nxt[1] = 1'b1;
      end else begin
        a_cl = va.closed;
        b_cl = has_b & vb.closed;
        if (mode == MODE_SINGLE) begin
          if (new_a) begin
            upd = 1'b1; r0 = va.start; r1 = '0; r2 = va.dur; r3 = '0;
          end
        end else if (!has_b) begin
          fault = 1'b1; flt_nxt[2] = 1'b1;
        end else begin
          if (va.count != vb.count) flt_nxt[3] = 1'b1;
          if (new_a && new_b) begin
            upd = 1'b1;
            r0 = (va.start > vb.start) ? va.start : vb.start;
            r1 = va.start - vb.start;
            r2 = va.dur; r3 = vb.dur;
          end
        end
      end
    end
  end

  // Hold per-gauge statistics; a mode write clears all gauges
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int k = 0; k < GaugeCount; k++) begin
        seen_a_r[k] <= '0; seen_b_r[k] <= '0; tot_r[k] <= '0;
        rec0_r[k] <= '0; rec1_r[k] <= '0; rec2_r[k] <= '0; rec3_r[k] <= '0;
        flt_r[k] <= {3'b0, (!rst_n) ? 1'b1 :
          (new_modes[2*k +: 2] == MODE_OFF || new_modes[2*k +: 2] == 2'd3)};
      end
    end else if (step) begin
      flt_r[g] <= flt_nxt;
      if (upd) begin
        seen_a_r[g] <= va.count;
        if (mode == MODE_DUAL) seen_b_r[g] <= vb.count;
        rec0_r[g] <= r0; rec1_r[g] <= r1; rec2_r[g] <= r2; rec3_r[g] <= r3;
        tot_r[g] <= tot_r[g] + 32'd1;
      end
    end
  end

  assign res = '{gauge_index: g, new_event: upd, event_time_us: r0, skew_us: r1,
                 closed_time_a_us: r2, closed_time_b_us: r3,
                 event_count: upd ? tot_r[g] + 32'd1 : tot_r[g],
                 reed_a_closed: a_cl, reed_b_closed: b_cl, fault: fault,
                 fault_bits: flt_nxt, last_of_run: g == 2'(GaugeCount - 1)};
endmodule

>>> design/reed_pair_event_monitor_top.sv
// Top level: reed pair event monitor
//   channel | dir | payload
//   in_     | in  | sample_time_us, reed_levels
//   out_    | out | one result per gauge, gauge 0 first
//   cfg_    | in  | register index and write data
// A sample is taken when no gauge sweep runs; the eight reed lanes update in
// that cycle, then the single shared gauge merger emits one gauge result per
// cycle unless the output stalls.
// Reset is synchronous. Output stalls hold the sweep.
// Output register lets the next sample enter while the last result waits.
`timescale 1ns / 1ps
module reed_pair_event_monitor_top
  import rpem_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  rpem_in_if.sink      in_ch,
  rpem_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  logic [15:0] deb_r;
  logic [7:0]  en_r, modes_r;
  logic        busy_r;
  logic [1:0]  g_r;
  logic        ov_r;
  result_t     ores_r, res;
  reed_view_t  views [ReedCount];
  logic        take, emit, clr;

  // Sweep advances when the output register is free or draining
  assign emit = busy_r && (!ov_r || out_ch.ready);
  assign in_ch.ready = !busy_r;
  assign take = in_ch.valid && !busy_r;
  assign clr = cfg_we && cfg_index == CFG_MODES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= 16'd5000; en_r <= 8'hFF; modes_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: deb_r <= cfg_wdata;
        CFG_ENABLE:   en_r <= cfg_wdata[7:0];
        CFG_MODES:    modes_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < ReedCount; i++) begin : g_lane
    rpem_reed_lane u_lane (
      .clk, .rst_n, .step(take), .present(en_r[i]), .lv(in_ch.reed_levels[i]),
      .now(in_ch.sample_time_us), .debounce_us(deb_r), .view(views[i]));
  end

  rpem_gauge_merge u_merge (
    .clk, .rst_n, .clr, .new_modes(cfg_wdata[7:0]), .step(emit), .g(g_r),
    .modes(modes_r), .en_mask(en_r), .va(views[{g_r, 1'b0}]),
    .vb(views[{g_r, 1'b1}]), .res);

  // Step through gauges and hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; g_r <= '0; ov_r <= 1'b0;
    end else begin
      if (take) busy_r <= 1'b1;
      if (emit) begin
        g_r <= g_r + 2'd1;
        if (g_r == 2'(GaugeCount - 1)) begin
          busy_r <= 1'b0; g_r <= '0;
        end
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) ores_r <= res;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.gauge_index = ores_r.gauge_index;
  assign out_ch.new_event = ores_r.new_event;
  assign out_ch.event_time_us = ores_r.event_time_us;
  assign out_ch.skew_us = ores_r.skew_us;
  assign out_ch.closed_time_a_us = ores_r.closed_time_a_us;
  assign out_ch.closed_time_b_us = ores_r.closed_time_b_us;
  assign out_ch.event_count = ores_r.event_count;
  assign out_ch.reed_a_closed = ores_r.reed_a_closed;
  assign out_ch.reed_b_closed = ores_r.reed_b_closed;
  assign out_ch.fault = ores_r.fault;
  assign out_ch.fault_bits = ores_r.fault_bits;
  assign out_ch.last_of_run = ores_r.last_of_run;
endmodule

>>> test/rpem_test_if.sv
// Test-side channel interfaces are taken from the design; this file holds the scoreboard class
`timescale 1ns / 1ps
package rpem_test_pkg;
  import rpem_pkg::*;

  class gauge_scoreboard;
    logic [15:0] debounce;
    logic [7:0]  enable_mask;
    logic [7:0]  modes;
    logic        prev_lvl [ReedCount];
    logic        edge_lvl [ReedCount];
    logic        edge_armed [ReedCount];
    logic [31:0] edge_at [ReedCount];
    logic        stable [ReedCount];
    logic [31:0] closures [ReedCount];
    logic [31:0] close_start [ReedCount];
    logic [31:0] closed_dur [ReedCount];
    logic [31:0] seen_a [GaugeCount];
    logic [31:0] seen_b [GaugeCount];
    logic [31:0] rec [GaugeCount][4];
    logic [31:0] totals [GaugeCount];
    logic [3:0]  flags [GaugeCount];
    result_t     pending_results [$];
    int          errors;

    function new();
      errors = 0;
      debounce = 16'd5000;
      enable_mask = 8'hFF;
      modes = 8'h00;
      for (int i = 0; i < ReedCount; i++) begin
        prev_lvl[i] = 1; edge_lvl[i] = 1; edge_armed[i] = 0; edge_at[i] = 0;
        stable[i] = 1; closures[i] = 0; close_start[i] = 0; closed_dur[i] = 0;
      end
      clear_all();
    endfunction

    function logic [1:0] mode_of(int g);
      logic [1:0] m;
      m = modes[2*g +: 2];
      return (m == 2'd3) ? MODE_OFF : m;
    endfunction

    function void clear_all();
      for (int g = 0; g < GaugeCount; g++) begin
        for (int k = 0; k < 4; k++) rec[g][k] = 0;
        totals[g] = 0; seen_a[g] = 0; seen_b[g] = 0;
        flags[g] = (mode_of(g) == MODE_OFF) ? 4'd1 : 4'd0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_DEBOUNCE: debounce = data;
        CFG_ENABLE: enable_mask = data[7:0];
        CFG_MODES: begin
          modes = data[7:0];
          clear_all();
        end
        default: ;
      endcase
    endfunction

    // Note an accepted sample and queue the four gauge results it causes
    function void note_sample(logic [31:0] now, logic [7:0] lv);
      result_t r;
      logic [1:0] m;
      logic [31:0] sa, sb;
      logic ha, hb, na, nb;
      for (int i = 0; i < ReedCount; i++) begin
        if (enable_mask[i] && lv[i] != prev_lvl[i]) begin
          edge_lvl[i] = lv[i]; edge_at[i] = now; edge_armed[i] = 1;
        end
        prev_lvl[i] = lv[i];
      end
      for (int i = 0; i < ReedCount; i++) begin
        if (!enable_mask[i] || !edge_armed[i]) continue;
        if (32'(now - edge_at[i]) < {16'd0, debounce}) continue;
        if (lv[i] != edge_lvl[i]) continue;
        edge_armed[i] = 0;
        if (lv[i] == stable[i]) continue;
        stable[i] = lv[i];
        if (!lv[i]) begin
          closures[i] = closures[i] + 1;
          close_start[i] = edge_at[i];
        end else begin
          closed_dur[i] = edge_at[i] - close_start[i];
        end
      end
      for (int g = 0; g < GaugeCount; g++) begin
        r = '0;
        ha = enable_mask[2*g];
        hb = enable_mask[2*g+1];
        m = mode_of(g);
        flags[g] &= 4'd1;
        if (m == MODE_OFF) begin
          flags[g] |= 4'd1;
        end else begin
          flags[g] = 0;
          if (!ha) begin
            r.fault = 1; flags[g] |= 4'd2;
          end else begin
            na = closures[2*g] != seen_a[g];
            r.reed_a_closed = !stable[2*g];
            r.reed_b_closed = hb && !stable[2*g+1];
            if (m == MODE_SINGLE) begin
              if (na) begin
                seen_a[g] = closures[2*g];
                rec[g][0] = close_start[2*g]; rec[g][1] = 0;
                rec[g][2] = closed_dur[2*g]; rec[g][3] = 0;
                totals[g] = totals[g] + 1;
                r.new_event = 1;
              end
            end else if (!hb) begin
              r.fault = 1; flags[g] |= 4'd4;
            end else begin
              nb = closures[2*g+1] != seen_b[g];
              if (closures[2*g] != closures[2*g+1]) flags[g] |= 4'd8;
              if (na && nb) begin
                sa = close_start[2*g]; sb = close_start[2*g+1];
                seen_a[g] = closures[2*g]; seen_b[g] = closures[2*g+1];
                rec[g][0] = (sa > sb) ? sa : sb; rec[g][1] = sa - sb;
                rec[g][2] = closed_dur[2*g]; rec[g][3] = closed_dur[2*g+1];
                totals[g] = totals[g] + 1;
                r.new_event = 1;
              end
            end
          end
        end
        r.gauge_index = g[1:0];
        r.event_time_us = rec[g][0];
        r.skew_us = rec[g][1];
        r.closed_time_a_us = rec[g][2];
        r.closed_time_b_us = rec[g][3];
        r.event_count = totals[g];
        r.fault_bits = flags[g];
        r.last_of_run = (g == GaugeCount - 1);
        pending_results.push_back(r);
      end
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(result_t got);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got !== exp_r) begin
        $display("%0t: result mismatch, expected %p, actual %p", $time, exp_r, got);
        errors++;
      end
    endfunction
  endclass
endpackage

>>> test/reed_pair_event_monitor_top_test.sv
// Testbench top: drives samples and register writes, checks gauge results
`timescale 1ns / 1ps
module reed_pair_event_monitor_top_test;
  import rpem_pkg::*;
  import rpem_test_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          cycles;
  int          hold_off;
  logic [31:0] clock_us;
  logic [7:0]  levels;

  rpem_in_if  in_ch ();
  rpem_out_if out_ch ();
  gauge_scoreboard board;

  reed_pair_event_monitor_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL reed_pair_event_monitor_top");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        board.check_result(out_ch.gauge_index === 2'bx ? '0 : {out_ch.gauge_index,
          out_ch.new_event, out_ch.event_time_us, out_ch.skew_us,
          out_ch.closed_time_a_us, out_ch.closed_time_b_us, out_ch.event_count,
          out_ch.reed_a_closed, out_ch.reed_b_closed, out_ch.fault,
          out_ch.fault_bits, out_ch.last_of_run});
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 30) == 0);
      end
    end
  end

  // Wait until no request is in flight, then write one register
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    while (board.pending_results.size() != 0) @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 0;
    board.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Offer one sample and hold it until taken; a gap follows at random, or always when gaps is off
  task automatic send_sample(logic [31:0] t, logic [7:0] lv, bit gaps);
    int gap;
    in_ch.valid <= 1; in_ch.sample_time_us <= t; in_ch.reed_levels <= lv;
    do @(posedge clk); while (!in_ch.ready);
    board.note_sample(t, lv);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end else if (!gaps) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Advance time by a random step: mostly short, sometimes past debounce
  task automatic random_sample(bit well_formed);
    int step;
    step = well_formed ? $urandom_range(1, 3000) : $urandom_range(0, 100000);
    if ($urandom_range(0, 20) == 0) step = $urandom();
    clock_us = clock_us + step;
    if (well_formed) begin
      if ($urandom_range(0, 2) == 0) levels = levels ^ (8'd1 << $urandom_range(0, 7));
      if ($urandom_range(0, 5) == 0) levels = ~levels;
    end else begin
      levels = $urandom();
    end
    send_sample(clock_us, levels, 1);
  endtask

  initial begin
    board = new();
    cycles = 0; hold_off = 0;
    rst_n = 0; cfg_we = 0; cfg_index = CFG_DEBOUNCE; cfg_wdata = 0;
    in_ch.valid = 0; in_ch.sample_time_us = 0; in_ch.reed_levels = 8'hFF;
    out_ch.ready = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: disabled gauges at reset, then all modes incl. mode 3
    send_sample(32'd0, 8'h00, 0);
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_MODES, {MODE_OFF + 2'd3, MODE_DUAL, MODE_DUAL, MODE_SINGLE});
    send_sample(32'd10, 8'hFF, 0);
    send_sample(32'd20, 8'h00, 0);
    send_sample(32'd30, 8'h0F, 0);
    send_sample(32'd45, 8'h3C, 0);
    send_sample(32'hFFFF_FFF0, 8'hFF, 0);
    send_sample(32'h0000_0010, 8'h00, 0);
    drain();
    // Missing reeds and count mismatch, max debounce with time wrap
    write_reg(CFG_ENABLE, 8'b1001_1110);
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    send_sample(32'hFFFF_0000, 8'hFF, 0);
    send_sample(32'hFFFF_8000, 8'h00, 0);
    send_sample(32'h0000_7FFF, 8'h55, 0);
    send_sample(32'h0000_8000, 8'h00, 0);
    send_sample(32'h0001_0000, 8'hAA, 0);
    drain();
    write_reg(3, 16'hFFFF);
    write_reg(CFG_ENABLE, 8'hFF);
    write_reg(CFG_MODES, 8'b1010_1010);
    clock_us = 32'h1000;
    levels = 8'hFF;

    // Random phases with varied settings
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_DEBOUNCE, (phase == 5) ? 16'hFFFF : 16'($urandom_range(0, 4000)));
      write_reg(CFG_ENABLE, (phase < 3) ? 8'hFF : 8'($urandom()));
      write_reg(CFG_MODES, (phase == 0) ? 8'h55 : (phase == 1) ? 8'hAA : 8'($urandom()));
      for (int n = 0; n < 55; n++) begin
        if (phase == 2 && n == 10) hold_off = 200;
        random_sample($urandom_range(0, 9) < 8);
      end
      drain();
    end

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("PASS reed_pair_event_monitor_top");
    end else begin
      $display("FAIL reed_pair_event_monitor_top");
    end
    $finish;
  end
endmodule
